/* rtl/osh_pkg.sv */
// shared constants, widths and control structs for the sample history ring
package osh_pkg;

	localparam int DEPTH   = 32;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int KIND_W  = 2;
	localparam int LEVEL_W = 7;
	localparam int TIME_W  = 32;
	localparam int REQ_W   = 6;
	localparam int POS_W   = 5;
	localparam int TOTAL_W = 6;
	localparam int CMP_W   = (CNT_W > REQ_W) ? CNT_W : REQ_W;
	localparam int ENTRY_W = TIME_W + LEVEL_W;

	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

	localparam logic [KIND_W-1:0] KIND_RECORD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic do_record;
		logic do_clear;
		logic start_read;
		logic issue;
	} osh_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;
		logic final_issue;
	} osh_stat_t;

endpackage

/* rtl/osh_ctrl.sv */
// controller: accepts words, decodes the kind and paces the read stream
module osh_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [osh_pkg::KIND_W-1:0] kind,
	input  osh_pkg::osh_stat_t        stat,
	output osh_pkg::osh_cmd_t         cmd
);
	import osh_pkg::*;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_STREAM
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		case (kind)
			KIND_RECORD: cmd.do_record  = accept;
			KIND_READ:   cmd.start_read = accept;
			KIND_CLEAR:  cmd.do_clear   = accept;
			default:     cmd            = '0;
		endcase
		cmd.issue = (state_q == ST_STREAM) && stat.slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start_read) begin
						state_q <= ST_STREAM;
					end
				end
				ST_STREAM: begin
					if (cmd.issue && stat.final_issue) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/osh_dpath.sv */
// datapath: sample memory, head and count, read pointer and output register
module osh_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  osh_pkg::osh_cmd_t           cmd,
	output osh_pkg::osh_stat_t          stat,
	input  logic [osh_pkg::LEVEL_W-1:0] level_in,
	input  logic [osh_pkg::TIME_W-1:0]  time_in,
	input  logic [osh_pkg::REQ_W-1:0]   max_count,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [osh_pkg::TIME_W-1:0]  out_time,
	output logic [osh_pkg::LEVEL_W-1:0] out_level,
	output logic [osh_pkg::POS_W-1:0]   out_position,
	output logic                        empty_res,
	output logic                        last,
	output logic [osh_pkg::TOTAL_W-1:0] total_stored
);
	import osh_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];

	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;

	// read run in progress
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] remain_q;
	logic [PTR_W-1:0] pos_q;
	logic [CNT_W-1:0] total_q;
	logic             rq_empty_q;

	// output register, the memory read data lands here
	logic               out_valid_q;
	logic [ENTRY_W-1:0] out_data_q;
	logic [PTR_W-1:0]   out_pos_q;
	logic               out_empty_q;
	logic               out_last_q;
	logic [CNT_W-1:0]   out_total_q;

	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] req_ext;
	logic [CNT_W-1:0] avail;
	logic [PTR_W-1:0] avail_ptr;
	logic [PTR_W-1:0] start_ptr;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] rd_ptr_inc;

	assign cnt_ext = CMP_W'(count_q);
	assign req_ext = CMP_W'(max_count);
	assign avail   = (cnt_ext < req_ext) ? count_q : CNT_W'(req_ext);
	// avail equals DEPTH only when the ring is full, which wraps to the head itself
	assign avail_ptr = PTR_W'(avail);

	always_comb begin
		if (avail == FULL_CNT) begin
			start_ptr = head_q;
		end else if (head_q >= avail_ptr) begin
			start_ptr = head_q - avail_ptr;
		end else begin
			start_ptr = PTR_W'(CNT_W'(head_q) + FULL_CNT - avail);
		end
	end

	assign head_inc   = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign rd_ptr_inc = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;

	assign stat.slot_free   = !out_valid_q || out_ready;
	assign stat.final_issue = rq_empty_q || (remain_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.do_record) begin
				head_q <= head_inc;
				if (count_q != FULL_CNT) begin
					count_q <= count_q + 1'b1;
				end
			end else if (cmd.do_clear) begin
				head_q  <= '0;
				count_q <= '0;
			end
			if (cmd.issue) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_record) begin
			mem[head_q] <= {time_in, level_in};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_read) begin
			rd_ptr_q   <= start_ptr;
			remain_q   <= avail;
			pos_q      <= '0;
			total_q    <= count_q;
			rq_empty_q <= (avail == '0);
		end else if (cmd.issue) begin
			rd_ptr_q <= rd_ptr_inc;
			remain_q <= remain_q - 1'b1;
			pos_q    <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			if (rq_empty_q) begin
				out_data_q <= '0;
				out_pos_q  <= '0;
			end else begin
				out_data_q <= mem[rd_ptr_q];
				out_pos_q  <= pos_q;
			end
			out_empty_q <= rq_empty_q;
			out_last_q  <= stat.final_issue;
			out_total_q <= total_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_time     = out_data_q[ENTRY_W-1:LEVEL_W];
	assign out_level    = out_data_q[LEVEL_W-1:0];
	assign out_position = POS_W'(out_pos_q);
	assign empty_res    = out_empty_q;
	assign last         = out_last_q;
	assign total_stored = TOTAL_W'(out_total_q);

endmodule

/* rtl/overwriting_sample_history_ring_top.sv */
// Overwriting sample history ring, top level.
//
// Input channel (in_valid/in_ready) carries one command word: kind selects
// record, read or clear. A record stores time_in and level_in at the head of
// a 32-entry ring and overwrites the oldest entry once the ring is full. A
// clear empties the ring. A read streams the newest min(stored, max_count)
// entries, oldest first, on the output channel (out_valid/out_ready), with
// last set on the final word; a request of zero or an empty ring gives a
// single word with empty_res and last set and zero data.
// Record and clear each act when accepted. A read loads the read pointer
// and remaining count when accepted; each entry is then read from the
// sample memory straight into the output register, and later entries
// follow every cycle while the receiver takes them. in_ready stays low
// while a read run is being issued. A stalled receiver holds the output
// word; the stream resumes once it is taken. After reset the ring is empty
// and head and count are zero; the memory contents are never cleared, only
// written entries can be read.
module overwriting_sample_history_ring_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [osh_pkg::KIND_W-1:0]  kind,
	input  logic [osh_pkg::LEVEL_W-1:0] level_in,
	input  logic [osh_pkg::TIME_W-1:0]  time_in,
	input  logic [osh_pkg::REQ_W-1:0]   max_count,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [osh_pkg::TIME_W-1:0]  out_time,
	output logic [osh_pkg::LEVEL_W-1:0] out_level,
	output logic [osh_pkg::POS_W-1:0]   out_position,
	output logic                        empty_res,
	output logic                        last,
	output logic [osh_pkg::TOTAL_W-1:0] total_stored
);
	import osh_pkg::*;

	osh_cmd_t  cmd;
	osh_stat_t stat;

	osh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.stat     (stat),
		.cmd      (cmd)
	);

	osh_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.level_in     (level_in),
		.time_in      (time_in),
		.max_count    (max_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_time     (out_time),
		.out_level    (out_level),
		.out_position (out_position),
		.empty_res    (empty_res),
		.last         (last),
		.total_stored (total_stored)
	);

endmodule

/* rtl/osh_chk.sv */
// port-level checker for the sample history ring, bound to the top level
module osh_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [osh_pkg::TIME_W-1:0]  out_time,
	input logic [osh_pkg::LEVEL_W-1:0] out_level,
	input logic [osh_pkg::POS_W-1:0]   out_position,
	input logic                        empty_res,
	input logic                        last,
	input logic [osh_pkg::TOTAL_W-1:0] total_stored
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_time) && $stable(out_level)
			&& $stable(out_position) && $stable(last) && $stable(empty_res))
		else $error("output word changed while stalled");

	// empty word is a lone, zeroed, final word
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> last && out_time == '0 && out_level == '0
			&& out_position == '0)
		else $error("malformed empty word");

	// a real entry lies within what the ring held
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !empty_res |-> total_stored != '0 && out_position < total_stored)
		else $error("entry position beyond stored count");

	// a run continues back to back with the next position
	a_run_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && !empty_res
			&& out_position == $past(out_position) + 5'd1)
		else $error("read run broke or skipped a position");

endmodule

bind overwriting_sample_history_ring_top osh_chk u_osh_chk (.*);

/* verif/overwriting_sample_history_ring_top_test.sv */
// self-checking testbench for the overwriting sample history ring
`timescale 1ns / 1ps

module overwriting_sample_history_ring_top_test;
	import osh_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 20;

	typedef struct {
		logic [TIME_W-1:0]  stamp;
		logic [LEVEL_W-1:0] level;
		logic [POS_W-1:0]   position;
		logic               is_empty;
		logic               is_last;
		logic [TOTAL_W-1:0] total;
	} history_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [KIND_W-1:0]   kind = KIND_RECORD;
	logic [LEVEL_W-1:0]  level_in = '0;
	logic [TIME_W-1:0]   time_in = '0;
	logic [REQ_W-1:0]    max_count = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [TIME_W-1:0]   out_time;
	logic [LEVEL_W-1:0]  out_level;
	logic [POS_W-1:0]    out_position;
	logic                empty_res;
	logic                last;
	logic [TOTAL_W-1:0]  total_stored;

	// own copy of the ring
	logic [TIME_W-1:0]   ring_stamp [DEPTH];
	logic [LEVEL_W-1:0]  ring_level [DEPTH];
	int                  ring_head = 0;
	int                  ring_count = 0;
	history_word_t       history_words_due [$];

	int fail_count = 0;
	int cycle_count = 0;
	bit tx_bursty = 1'b0;
	int burst_left = 0;
	bit rx_stalls = 1'b0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int rx_run_left = 0;
	bit rx_run_ready = 1'b1;

	overwriting_sample_history_ring_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.level_in(level_in),
		.time_in(time_in),
		.max_count(max_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_time(out_time),
		.out_level(out_level),
		.out_position(out_position),
		.empty_res(empty_res),
		.last(last),
		.total_stored(total_stored)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// words a command adds to the history stream
	function automatic void predict_history_words(input logic [KIND_W-1:0] k,
			input logic [LEVEL_W-1:0] lvl, input logic [TIME_W-1:0] stamp,
			input logic [REQ_W-1:0] req);
		int avail;
		int first;
		history_word_t w;
		case (k)
			KIND_RECORD: begin
				ring_stamp[ring_head] = stamp;
				ring_level[ring_head] = lvl;
				ring_head = (ring_head + 1) % DEPTH;
				if (ring_count < DEPTH)
					ring_count++;
			end
			KIND_CLEAR: begin
				ring_head = 0;
				ring_count = 0;
			end
			KIND_READ: begin
				avail = (ring_count < int'(req)) ? ring_count : int'(req);
				w.total = TOTAL_W'(ring_count);
				if (avail == 0) begin
					w.stamp = '0;
					w.level = '0;
					w.position = '0;
					w.is_empty = 1'b1;
					w.is_last = 1'b1;
					history_words_due.push_back(w);
				end else begin
					first = (ring_head + DEPTH - avail) % DEPTH;
					for (int i = 0; i < avail; i++) begin
						w.stamp = ring_stamp[(first + i) % DEPTH];
						w.level = ring_level[(first + i) % DEPTH];
						w.position = POS_W'(i);
						w.is_empty = 1'b0;
						w.is_last = (i == avail - 1);
						history_words_due.push_back(w);
					end
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin : check_words
		history_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (history_words_due.size() == 0) begin
				$error("history word with nothing expected: time %h level %0d pos %0d",
					out_time, out_level, out_position);
				fail_count++;
			end else begin
				w = history_words_due.pop_front();
				if (out_time !== w.stamp) begin
					$error("out_time: expected %h, got %h", w.stamp, out_time);
					fail_count++;
				end
				if (out_level !== w.level) begin
					$error("out_level: expected %0d, got %0d", w.level, out_level);
					fail_count++;
				end
				if (out_position !== w.position) begin
					$error("out_position: expected %0d, got %0d", w.position, out_position);
					fail_count++;
				end
				if (empty_res !== w.is_empty) begin
					$error("empty_res: expected %b, got %b", w.is_empty, empty_res);
					fail_count++;
				end
				if (last !== w.is_last) begin
					$error("last: expected %b, got %b", w.is_last, last);
					fail_count++;
				end
				if (total_stored !== w.total) begin
					$error("total_stored: expected %0d, got %0d", w.total, total_stored);
					fail_count++;
				end
			end
		end
	end

	// receiver: random ready/stall runs, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else if (rx_stalls) begin
			if (rx_run_left == 0) begin
				rx_run_ready = ($urandom_range(0, 2) != 0);
				rx_run_left = rx_run_ready ? $urandom_range(1, 10) : $urandom_range(1, 6);
			end
			rx_run_left--;
			out_ready = rx_run_ready;
		end else begin
			out_ready = 1'b1;
		end
	end

	task automatic send_word(input logic [KIND_W-1:0] k, input logic [LEVEL_W-1:0] lvl,
			input logic [TIME_W-1:0] stamp, input logic [REQ_W-1:0] req);
		int gap;
		@(negedge clk);
		if (tx_bursty) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
				burst_left = $urandom_range(1, 8);
			end
			burst_left--;
		end
		kind = k;
		level_in = lvl;
		time_in = stamp;
		max_count = req;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_history_words(k, lvl, stamp, req);
	endtask

	// wait for every outstanding word, then let the block settle
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (history_words_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [LEVEL_W-1:0] pick_level();
		// mostly valid percentages, sometimes out of range
		return ($urandom_range(0, 9) == 0) ? LEVEL_W'($urandom_range(101, 127))
			: LEVEL_W'($urandom_range(0, 100));
	endfunction

	function automatic logic [REQ_W-1:0] pick_request();
		return ($urandom_range(0, 9) == 0) ? REQ_W'($urandom_range(33, 63))
			: REQ_W'($urandom_range(0, DEPTH));
	endfunction

	task automatic send_random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 52)
			send_word(KIND_RECORD, pick_level(), $urandom, pick_request());
		else if (r < 88)
			send_word(KIND_READ, pick_level(), $urandom, pick_request());
		else if (r < 94)
			send_word(KIND_CLEAR, pick_level(), $urandom, pick_request());
		else
			send_word(KIND_UNUSED, pick_level(), $urandom, pick_request());
	endtask

	task automatic test_empty_history();
		send_word(KIND_READ, '0, '0, 6'd0);
		send_word(KIND_READ, '0, '0, 6'd5);
		send_word(KIND_READ, 7'd127, 32'hFFFF_FFFF, 6'd63);
		send_word(KIND_CLEAR, '0, '0, '0);
		send_word(KIND_UNUSED, 7'd127, 32'hFFFF_FFFF, 6'd63);
		send_word(KIND_READ, '0, '0, 6'd1);
	endtask

	task automatic test_field_extremes();
		send_word(KIND_RECORD, 7'd0, 32'h0000_0000, 6'd0);
		send_word(KIND_RECORD, 7'd127, 32'hFFFF_FFFF, 6'd63);
		send_word(KIND_RECORD, 7'd100, 32'h8000_0000, 6'd32);
		send_word(KIND_RECORD, 7'd64, 32'h0000_0001, 6'd1);
		send_word(KIND_READ, '0, '0, 6'd0);
		send_word(KIND_READ, 7'd127, 32'hFFFF_FFFF, 6'd63);
		send_word(KIND_READ, '0, '0, 6'd1);
		send_word(KIND_READ, '0, '0, 6'd4);
		send_word(KIND_UNUSED, 7'd33, 32'h5555_AAAA, 6'd2);
		send_word(KIND_READ, '0, '0, 6'd2);
		send_word(KIND_CLEAR, 7'd127, 32'hFFFF_FFFF, 6'd63);
		send_word(KIND_READ, '0, '0, 6'd32);
		send_word(KIND_RECORD, 7'd55, 32'h1234_5678, 6'd0);
		send_word(KIND_READ, '0, '0, 6'd32);
	endtask

	// more records than slots, so the oldest get overwritten
	task automatic test_wrap_overwrite();
		repeat (40) send_word(KIND_RECORD, pick_level(), $urandom, pick_request());
		send_word(KIND_READ, pick_level(), $urandom, 6'd32);
		send_word(KIND_READ, pick_level(), $urandom, 6'd63);
		send_word(KIND_READ, pick_level(), $urandom, 6'd17);
	endtask

	task automatic test_random_traffic(input int n);
		repeat (n) send_random_item();
	endtask

	// receiver holds off while reads keep coming, so the input stalls
	task automatic test_input_backpressure();
		repeat (20) send_word(KIND_RECORD, pick_level(), $urandom, pick_request());
		hold_requests++;
		repeat (4) send_word(KIND_READ, pick_level(), $urandom, 6'd32);
		repeat (3) send_word(KIND_RECORD, pick_level(), $urandom, pick_request());
		send_word(KIND_READ, pick_level(), $urandom, 6'd63);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_bursty = 1'b0;
		rx_stalls = 1'b0;
		test_empty_history();
		test_field_extremes();

		tx_bursty = 1'b1;
		rx_stalls = 1'b1;
		test_wrap_overwrite();
		test_random_traffic(60);

		tx_bursty = 1'b0;
		rx_stalls = 1'b0;
		test_random_traffic(40);

		tx_bursty = 1'b1;
		test_input_backpressure();

		wait_drained();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
